FILE: sv/cwu_pkg.sv
// Package with shared types, constants and helpers for the coverage window update block.
package cwu_pkg;

  localparam int COARSE_ROWS_DEF = 64;
  localparam int COARSE_COLS_DEF = 64;
  localparam int MAX_SCALE_DEF   = 4;
  localparam int CFG_W           = 7;
  localparam int CFG_IDX_W       = 2;
  localparam int PWR_W           = 24;

  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_WINDOW = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [1:0] CELL_FREE     = 2'd0;
  localparam logic [1:0] CELL_OBSTACLE = 2'd1;
  localparam logic [1:0] CELL_SCANNED  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE = 2'd2;

  localparam logic signed [PWR_W-1:0] POWER_RESET = 24'sd64000;
  localparam logic signed [PWR_W-1:0] POWER_MAX   = 24'sh7FFFFF;
  localparam logic signed [PWR_W-1:0] POWER_MIN   = 24'sh800000;

  typedef struct packed {
    logic [1:0]        op;
    logic [7:0]        row;
    logic [7:0]        col;
    logic [1:0]        cell_value;
    logic [5:0]        reach;
    logic signed [15:0] power;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               coarse_state;
    logic signed [PWR_W-1:0]  power_level;
  } out_item_t;

  // Classified command passed from the front end to the back end.
  typedef struct packed {
    logic [1:0]         op;
    logic [8:0]         r0;
    logic [8:0]         r1;
    logic [8:0]         c0;
    logic [8:0]         c1;
    logic               empty;
    logic               hit;
    logic [7:0]         row;
    logic [7:0]         col;
    logic [1:0]         cell_value;
    logic signed [15:0] power;
  } cmd_t;

endpackage

FILE: sv/cwu_ram.sv
// Generic single-port RAM with registered read data.
module cwu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: sv/cwu_front.sv
// Front end: takes input transactions, clips windows and checks bounds.
module cwu_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cwu_pkg::in_item_t  in_data,
  input  logic [8:0]         rows_eff,
  input  logic [8:0]         cols_eff,
  input  logic [8:0]         fine_rows,
  input  logic [8:0]         fine_cols,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output cwu_pkg::cmd_t      cmd
);
  import cwu_pkg::*;

  logic  full_r, full_nxt;
  cmd_t  cmd_r, cmd_nxt;
  logic signed [9:0] r0s, c0s;
  logic [9:0] r1s, c1s;
  logic [8:0] r1c, c1c;

  assign in_ready  = !full_r || cmd_ready;
  assign cmd_valid = full_r;
  assign cmd       = cmd_r;

  always_comb begin
    r0s = $signed({2'b00, in_data.row}) - $signed({4'b0, in_data.reach});
    c0s = $signed({2'b00, in_data.col}) - $signed({4'b0, in_data.reach});
    r1s = {2'b00, in_data.row} + {4'b0, in_data.reach};
    c1s = {2'b00, in_data.col} + {4'b0, in_data.reach};
    r1c = (r1s > ({1'b0, rows_eff} - 10'd1)) ? rows_eff - 9'd1 : r1s[8:0];
    c1c = (c1s > ({1'b0, cols_eff} - 10'd1)) ? cols_eff - 9'd1 : c1s[8:0];
    cmd_nxt            = cmd_r;
    cmd_nxt.op         = in_data.op;
    cmd_nxt.row        = in_data.row;
    cmd_nxt.col        = in_data.col;
    cmd_nxt.cell_value = in_data.cell_value;
    cmd_nxt.power      = in_data.power;
    cmd_nxt.r0         = r0s[9] ? 9'd0 : r0s[8:0];
    cmd_nxt.c0         = c0s[9] ? 9'd0 : c0s[8:0];
    cmd_nxt.r1         = r1c;
    cmd_nxt.c1         = c1c;
    cmd_nxt.empty      = (rows_eff == 9'd0) || (cols_eff == 9'd0)
                         || ({1'b0, cmd_nxt.r0} > {1'b0, r1c})
                         || ({1'b0, cmd_nxt.c0} > {1'b0, c1c});
    unique case (in_data.op)
      OP_WRITE: cmd_nxt.hit = (in_data.cell_value != 2'd3)
                              && ({1'b0, in_data.row} < fine_rows)
                              && ({1'b0, in_data.col} < fine_cols);
      OP_READ:  cmd_nxt.hit = ({1'b0, in_data.row} < rows_eff)
                              && ({1'b0, in_data.col} < cols_eff);
      default:  cmd_nxt.hit = 1'b0;
    endcase
    full_nxt = full_r;
    if (cmd_ready) begin
      full_nxt = 1'b0;
    end
    if (in_valid && in_ready) begin
      full_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else begin
      full_r <= full_nxt;
    end
    if (in_valid && in_ready) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule

FILE: sv/cwu_back.sv
// Back end: clears the grids and executes writes, window sweeps and reads.
module cwu_back #(
  parameter int COARSE_ROWS = cwu_pkg::COARSE_ROWS_DEF,
  parameter int COARSE_COLS = cwu_pkg::COARSE_COLS_DEF,
  parameter int MAX_SCALE   = cwu_pkg::MAX_SCALE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  cwu_pkg::cmd_t      cmd,
  input  logic [4:0]         scale,
  output logic               out_valid,
  input  logic               out_ready,
  output cwu_pkg::out_item_t out_data,
  output logic               busy
);
  import cwu_pkg::*;

  localparam int FR = COARSE_ROWS * MAX_SCALE;
  localparam int FC = COARSE_COLS * MAX_SCALE;
  localparam int FRW = $clog2(FR) > 0 ? $clog2(FR) : 1;
  localparam int FCW = $clog2(FC) > 0 ? $clog2(FC) : 1;
  localparam int CRW = $clog2(COARSE_ROWS) > 0 ? $clog2(COARSE_ROWS) : 1;
  localparam int CCW = $clog2(COARSE_COLS) > 0 ? $clog2(COARSE_COLS) : 1;
  localparam int FDEPTH = 1 << (FRW + FCW);
  localparam int CDEPTH = 1 << (CRW + CCW);
  localparam int SW = 5;
  localparam int FAW = FRW + FCW;
  localparam int CAW = CRW + CCW;

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_FADDR = 4'd2;
  localparam logic [3:0] ST_FWAIT = 4'd3;
  localparam logic [3:0] ST_FDATA = 4'd4;
  localparam logic [3:0] ST_CRD   = 4'd5;
  localparam logic [3:0] ST_CWAIT = 4'd6;
  localparam logic [3:0] ST_CWR   = 4'd7;
  localparam logic [3:0] ST_RWAIT = 4'd8;
  localparam logic [3:0] ST_RDATA = 4'd9;
  localparam logic [3:0] ST_OUT   = 4'd10;

  logic [3:0] st_r, st_nxt;
  logic [FAW:0] clr_r, clr_nxt;
  cmd_t cmd_r;
  logic [8:0] r_r, r_nxt, c_r, c_nxt;
  logic [SW-1:0] a_r, a_nxt, b_r, b_nxt;
  logic obs_r, obs_nxt, all_r, all_nxt;
  logic ov_r, ov_nxt;
  out_item_t od_r, od_nxt;

  logic f_we, c_we;
  logic [FAW-1:0] f_addr;
  logic [CAW-1:0] c_addr;
  logic [1:0] f_wd, f_rd, cs_wd, cs_rd;
  logic [PWR_W-1:0] p_wd, p_rd;
  logic [15:0] fr_full, fc_full;
  logic signed [PWR_W:0] sum;
  logic [PWR_W-1:0] sat;

  cwu_ram #(.WIDTH(2), .DEPTH(FDEPTH)) u_fine (
    .clk(clk), .we(f_we), .addr(f_addr), .wdata(f_wd), .rdata(f_rd));
  cwu_ram #(.WIDTH(2), .DEPTH(CDEPTH)) u_coarse (
    .clk(clk), .we(c_we), .addr(c_addr), .wdata(cs_wd), .rdata(cs_rd));
  cwu_ram #(.WIDTH(PWR_W), .DEPTH(CDEPTH)) u_power (
    .clk(clk), .we(c_we), .addr(c_addr), .wdata(p_wd), .rdata(p_rd));

  assign cmd_ready = (st_r == ST_IDLE);
  assign out_valid = ov_r;
  assign out_data  = od_r;
  assign busy      = (st_r != ST_IDLE) || ov_r;

  always_comb begin
    fr_full = 16'(r_r[7:0] * scale) + 16'(a_r);
    fc_full = 16'(c_r[7:0] * scale) + 16'(b_r);
    sum = $signed({p_rd[PWR_W-1], p_rd}) + $signed({{9{cmd_r.power[15]}}, cmd_r.power});
    if (sum > $signed({POWER_MAX[PWR_W-1], POWER_MAX})) begin
      sat = POWER_MAX;
    end else if (sum < $signed({POWER_MIN[PWR_W-1], POWER_MIN})) begin
      sat = POWER_MIN;
    end else begin
      sat = sum[PWR_W-1:0];
    end
  end

  always_comb begin
    st_nxt  = st_r;
    clr_nxt = clr_r;
    r_nxt   = r_r;
    c_nxt   = c_r;
    a_nxt   = a_r;
    b_nxt   = b_r;
    obs_nxt = obs_r;
    all_nxt = all_r;
    ov_nxt  = ov_r;
    od_nxt  = od_r;
    f_we    = 1'b0;
    c_we    = 1'b0;
    f_addr  = {fr_full[FRW-1:0], fc_full[FCW-1:0]};
    c_addr  = {r_r[CRW-1:0], c_r[CCW-1:0]};
    f_wd    = CELL_FREE;
    cs_wd   = cs_rd;
    p_wd    = p_rd;
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end
    unique case (st_r)
      ST_CLEAR: begin
        f_we    = 1'b1;
        c_we    = clr_r < (FAW+1)'(CDEPTH);
        f_addr  = clr_r[FAW-1:0];
        c_addr  = clr_r[CAW-1:0];
        cs_wd   = CELL_FREE;
        p_wd    = POWER_RESET;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (FAW+1)'(FDEPTH - 1)) begin
          st_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_valid) begin
          r_nxt = cmd.r0;
          c_nxt = cmd.c0;
          a_nxt = '0;
          b_nxt = '0;
          obs_nxt = 1'b0;
          all_nxt = 1'b1;
          unique case (cmd.op)
            OP_WRITE: begin
              f_we   = cmd.hit;
              f_addr = {FRW'(cmd.row), FCW'(cmd.col)};
              f_wd   = cmd.cell_value;
              st_nxt = ST_OUT;
            end
            OP_WINDOW: st_nxt = cmd.empty ? ST_OUT : ST_FADDR;
            OP_READ: begin
              r_nxt  = {1'b0, cmd.row};
              c_nxt  = {1'b0, cmd.col};
              st_nxt = cmd.hit ? ST_RWAIT : ST_OUT;
            end
            default: st_nxt = ST_OUT;
          endcase
        end
      end
      ST_FADDR: st_nxt = ST_FWAIT;
      ST_FWAIT: begin
        st_nxt = ST_FDATA;
        if (b_r == scale - 1'b1) begin
          b_nxt = '0;
          a_nxt = a_r + 1'b1;
        end else begin
          b_nxt = b_r + 1'b1;
        end
      end
      ST_FDATA: begin
        if (f_rd == CELL_OBSTACLE) obs_nxt = 1'b1;
        if (f_rd != CELL_SCANNED) all_nxt = 1'b0;
        st_nxt = (a_r == scale) ? ST_CRD : ST_FWAIT;
      end
      ST_CRD:   st_nxt = ST_CWAIT;
      ST_CWAIT: st_nxt = ST_CWR;
      ST_CWR: begin
        c_we = 1'b1;
        if (all_r) begin
          cs_wd = CELL_SCANNED;
          p_wd  = sat;
        end
        if (obs_r) cs_wd = CELL_OBSTACLE;
        a_nxt = '0;
        b_nxt = '0;
        obs_nxt = 1'b0;
        all_nxt = 1'b1;
        if (c_r == cmd_r.c1) begin
          c_nxt = cmd_r.c0;
          r_nxt = r_r + 1'b1;
          st_nxt = (r_r == cmd_r.r1) ? ST_OUT : ST_FADDR;
        end else begin
          c_nxt = c_r + 1'b1;
          st_nxt = ST_FADDR;
        end
      end
      ST_RWAIT: st_nxt = ST_RDATA;
      ST_RDATA: st_nxt = ST_OUT;
      ST_OUT: begin
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1;
          od_nxt = '0;
          if (cmd_r.op == OP_READ && cmd_r.hit) begin
            od_nxt.coarse_state = cs_rd;
            od_nxt.power_level  = p_rd;
          end
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_CLEAR;
      clr_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      clr_r <= clr_nxt;
      ov_r  <= ov_nxt;
    end
    if (cmd_valid && cmd_ready) begin
      cmd_r <= cmd;
    end
    r_r   <= r_nxt;
    c_r   <= c_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    obs_r <= obs_nxt;
    all_r <= all_nxt;
    od_r  <= od_nxt;
  end

endmodule

FILE: sv/coverage_window_update.sv
// Top level of the coverage window update block.
//
//  port group | direction | handshake
//  in_        | input     | in_valid / in_ready, in_data
//  out_       | output    | out_valid / out_ready, out_data
//  cfg_       | input     | cfg_we, cfg_index, cfg_data
//
// A window update reads the fine cells of each covered coarse cell one at a time
// through the single read port of the fine grid memory.
// After reset, a clearing pass over 2^(fine address bits) addresses (65536 at the
// defaults) sweeps the grids before any transaction is carried out; the front
// end can hold one transaction meanwhile.
// One queue slot parts the front end from the back end; the output register
// lets the next transaction enter while a result waits.
module coverage_window_update #(
  parameter int COARSE_ROWS = cwu_pkg::COARSE_ROWS_DEF,
  parameter int COARSE_COLS = cwu_pkg::COARSE_COLS_DEF,
  parameter int MAX_SCALE   = cwu_pkg::MAX_SCALE_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  cwu_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output cwu_pkg::out_item_t         out_data,
  input  logic                       cfg_we,
  input  logic [cwu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cwu_pkg::CFG_W-1:0]  cfg_data
);
  import cwu_pkg::*;

  logic [6:0] rows_r, cols_r;
  logic [2:0] scale_r;
  logic [8:0] rows_eff, cols_eff, fine_rows, fine_cols;
  logic [4:0] scale_eff;
  logic cmd_valid, cmd_ready, busy;
  cmd_t cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r  <= 7'd64;
      cols_r  <= 7'd64;
      scale_r <= 3'd4;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROWS:  rows_r  <= cfg_data;
        REG_COLS:  cols_r  <= cfg_data;
        REG_SCALE: scale_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    rows_eff  = (32'(rows_r) > COARSE_ROWS) ? 9'(COARSE_ROWS) : {2'b0, rows_r};
    cols_eff  = (32'(cols_r) > COARSE_COLS) ? 9'(COARSE_COLS) : {2'b0, cols_r};
    if (scale_r == 3'd0) begin
      scale_eff = 5'd1;
    end else if (32'(scale_r) > MAX_SCALE) begin
      scale_eff = 5'(MAX_SCALE);
    end else begin
      scale_eff = {2'b0, scale_r};
    end
    fine_rows = (COARSE_ROWS * MAX_SCALE > 256) ? 9'd256 : 9'(COARSE_ROWS * MAX_SCALE);
    fine_cols = (COARSE_COLS * MAX_SCALE > 256) ? 9'd256 : 9'(COARSE_COLS * MAX_SCALE);
  end

  cwu_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .rows_eff(rows_eff), .cols_eff(cols_eff),
    .fine_rows(fine_rows), .fine_cols(fine_cols),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd));

  cwu_back #(
    .COARSE_ROWS(COARSE_ROWS), .COARSE_COLS(COARSE_COLS), .MAX_SCALE(MAX_SCALE)
  ) u_back (
    .clk(clk), .rst_n(rst_n),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
    .scale(scale_eff),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .busy(busy));

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_read_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.coarse_state != 2'd3)
    else $error("invalid coarse state");

  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !busy && !cmd_valid |-> in_ready)
    else $error("front stalled while back idle");

endmodule

FILE: tb/sv/coverage_window_update_tb.sv
// Self-checking testbench for the coverage window update block.
module coverage_window_update_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cwu_pkg::*;

  localparam logic [1:0] OP_NONE      = 2'd3;
  localparam logic [1:0] CELL_IGNORED = 2'd3;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;

  typedef struct {
    in_item_t  it;
    bit        known;
    out_item_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  logic [1:0] fine_map [0:255][0:255];
  logic [1:0] coarse_map [0:COARSE_ROWS_DEF-1][0:COARSE_COLS_DEF-1];
  logic signed [PWR_W-1:0] power_map [0:COARSE_ROWS_DEF-1][0:COARSE_COLS_DEF-1];
  int rows_cfg, cols_cfg, scale_cfg;

  out_item_t result_q[$];
  stim_row_t stim_q[$];
  int errs = 0;
  int sent = 0;
  bit idle_on = 1'b0;
  bit hold_req = 1'b0;

  coverage_window_update uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int used_rows();
    return rows_cfg > COARSE_ROWS_DEF ? COARSE_ROWS_DEF : rows_cfg;
  endfunction

  function automatic int used_cols();
    return cols_cfg > COARSE_COLS_DEF ? COARSE_COLS_DEF : cols_cfg;
  endfunction

  function automatic int used_scale();
    if (scale_cfg == 0) return 1;
    return scale_cfg > MAX_SCALE_DEF ? MAX_SCALE_DEF : scale_cfg;
  endfunction

  function automatic out_item_t apply_item(in_item_t it);
    out_item_t res;
    int s, r0, r1, c0, c1, pw, sum, scanned;
    bit obst;
    res = '0;
    case (it.op)
      OP_WRITE: begin
        if (it.cell_value != CELL_IGNORED) fine_map[it.row][it.col] = it.cell_value;
      end
      OP_WINDOW: begin
        s = used_scale();
        pw = $signed(it.power);
        r0 = int'(it.row) - int'(it.reach);
        r1 = int'(it.row) + int'(it.reach);
        c0 = int'(it.col) - int'(it.reach);
        c1 = int'(it.col) + int'(it.reach);
        if (r0 < 0) r0 = 0;
        if (c0 < 0) c0 = 0;
        if (r1 > used_rows() - 1) r1 = used_rows() - 1;
        if (c1 > used_cols() - 1) c1 = used_cols() - 1;
        for (int r = r0; r <= r1; r++) begin
          for (int c = c0; c <= c1; c++) begin
            scanned = 0;
            obst = 1'b0;
            for (int a = 0; a < s; a++) begin
              for (int b = 0; b < s; b++) begin
                if (fine_map[r*s+a][c*s+b] == CELL_OBSTACLE) obst = 1'b1;
                if (fine_map[r*s+a][c*s+b] == CELL_SCANNED) scanned++;
              end
            end
            if (scanned == s * s) begin
              sum = int'(power_map[r][c]) + pw;
              if (sum > int'(POWER_MAX)) sum = int'(POWER_MAX);
              if (sum < int'(POWER_MIN)) sum = int'(POWER_MIN);
              coarse_map[r][c] = CELL_SCANNED;
              power_map[r][c] = sum[PWR_W-1:0];
            end
            if (obst) coarse_map[r][c] = CELL_OBSTACLE;
          end
        end
      end
      OP_READ: begin
        if (it.row < used_rows() && it.col < used_cols()) begin
          res.coarse_state = coarse_map[it.row][it.col];
          res.power_level = power_map[it.row][it.col];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic in_item_t mk(logic [1:0] op, int row, int col, logic [1:0] v,
                                  int reach, int pw);
    in_item_t it;
    it.op = op;
    it.row = row[7:0];
    it.col = col[7:0];
    it.cell_value = v;
    it.reach = reach[5:0];
    it.power = pw[15:0];
    return it;
  endfunction

  function automatic int draw_gap();
    if (!idle_on || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 19);
  endfunction

  task automatic report(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errs++;
  endtask

  task automatic add_row(in_item_t it, bit known, logic [1:0] st, int lvl);
    stim_row_t row;
    row.it = it;
    row.known = known;
    row.want.coarse_state = st;
    row.want.power_level = lvl[PWR_W-1:0];
    stim_q = {stim_q, row};
  endtask

  task automatic send(in_item_t it, bit known, out_item_t want);
    out_item_t pred;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    pred = apply_item(it);
    result_q = {result_q, (known ? want : pred)};
    sent++;
  endtask

  task automatic send_pred(in_item_t it);
    int g;
    g = draw_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    send(it, 1'b0, '0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_ROWS:  rows_cfg = val & 'h7F;
      REG_COLS:  cols_cfg = val & 'h7F;
      REG_SCALE: scale_cfg = val & 'h7;
      default: ;
    endcase
  endtask

  task automatic run_phase(int nrows, int ncols, int scale, int n, int reach_max,
                           bit with_pressure);
    int first, s, r, c, span;
    logic [1:0] v;
    drain();
    write_reg(REG_ROWS, nrows);
    write_reg(REG_COLS, ncols);
    write_reg(REG_SCALE, scale);
    idle_on = $urandom_range(0, 1);
    first = sent;
    while (sent - first < n) begin
      if (with_pressure && sent - first > n / 3 && !hold_req) begin
        hold_req = 1'b1;
        with_pressure = 1'b0;
      end
      if ($urandom_range(0, 3) != 0) begin
        s = used_scale();
        span = used_rows() < 8 ? used_rows() : 8;
        r = $urandom_range(0, span > 0 ? span - 1 : 0);
        span = used_cols() < 8 ? used_cols() : 8;
        c = $urandom_range(0, span > 0 ? span - 1 : 0);
        for (int a = 0; a < s; a++) begin
          for (int b = 0; b < s; b++) begin
            v = ($urandom_range(0, 9) < 8) ? CELL_SCANNED : 2'($urandom_range(0, 3));
            send_pred(mk(OP_WRITE, r*s+a, c*s+b, v, $urandom_range(0, 63), $urandom));
          end
        end
        send_pred(mk(OP_WINDOW, r, c, 2'($urandom_range(0, 3)),
                     $urandom_range(0, reach_max < 2 ? reach_max : 2), $urandom));
        send_pred(mk(OP_READ, r + $urandom_range(0, 1), c + $urandom_range(0, 1),
                     2'($urandom_range(0, 3)), $urandom_range(0, 63), $urandom));
      end else begin
        send_pred(mk(2'($urandom_range(0, 3)), $urandom_range(0, 255),
                     $urandom_range(0, 255), 2'($urandom_range(0, 3)),
                     $urandom_range(0, reach_max), $urandom));
      end
      if (sent - first > n / 2 && sent - first < n / 2 + 20 && reach_max == 3) drain();
    end
  endtask

  initial begin
    #40_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  always begin
    int g;
    @(posedge clk);
    if (hold_req) begin
      out_ready <= 1'b0;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_req = 1'b0;
    end else begin
      g = draw_gap();
      if (g > 0) begin
        out_ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
    out_ready <= 1'b1;
    do @(posedge clk); while (!out_valid);
    out_ready <= 1'b0;
    if (result_q.size() == 0) begin
      report("result arrived with no transaction outstanding");
    end else begin
      out_item_t exp_res;
      exp_res = result_q.pop_front();
      if (out_data.coarse_state !== exp_res.coarse_state)
        report($sformatf("coarse_state %0d, expected %0d",
                         out_data.coarse_state, exp_res.coarse_state));
      if (out_data.power_level !== exp_res.power_level)
        report($sformatf("power_level %0d, expected %0d",
                         out_data.power_level, exp_res.power_level));
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    for (int r = 0; r < 256; r++)
      for (int c = 0; c < 256; c++)
        fine_map[r][c] = CELL_FREE;
    for (int r = 0; r < COARSE_ROWS_DEF; r++)
      for (int c = 0; c < COARSE_COLS_DEF; c++) begin
        coarse_map[r][c] = CELL_FREE;
        power_map[r][c] = POWER_RESET;
      end
    rows_cfg = COARSE_ROWS_DEF;
    cols_cfg = COARSE_COLS_DEF;
    scale_cfg = MAX_SCALE_DEF;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed transactions run at one fine cell per coarse cell.
    write_reg(REG_SCALE, 1);
    add_row(mk(OP_READ, 0, 0, 0, 0, 0), 1, CELL_FREE, 64000);
    add_row(mk(OP_READ, 63, 63, 0, 0, 0), 1, CELL_FREE, 64000);
    add_row(mk(OP_READ, 64, 0, 0, 0, 0), 1, CELL_FREE, 0);
    add_row(mk(OP_READ, 255, 255, 3, 63, -1), 1, CELL_FREE, 0);
    add_row(mk(OP_NONE, 255, 255, 3, 63, -1), 1, CELL_FREE, 0);
    add_row(mk(OP_WRITE, 255, 255, CELL_IGNORED, 0, 0), 1, CELL_FREE, 0);
    add_row(mk(OP_WRITE, 0, 0, CELL_SCANNED, 0, 0), 1, CELL_FREE, 0);
    add_row(mk(OP_WINDOW, 0, 0, 0, 0, 32767), 1, CELL_FREE, 0);
    add_row(mk(OP_READ, 0, 0, 0, 0, 0), 1, CELL_SCANNED, 96767);
    add_row(mk(OP_WRITE, 1, 1, CELL_OBSTACLE, 0, 0), 1, CELL_FREE, 0);
    add_row(mk(OP_WINDOW, 1, 1, 0, 0, 100), 1, CELL_FREE, 0);
    add_row(mk(OP_READ, 1, 1, 0, 0, 0), 1, CELL_OBSTACLE, 64000);
    add_row(mk(OP_WINDOW, 0, 0, 0, 0, -32768), 1, CELL_FREE, 0);
    add_row(mk(OP_READ, 0, 0, 0, 0, 0), 1, CELL_SCANNED, 63999);
    add_row(mk(OP_WINDOW, 255, 255, 0, 63, 32767), 1, CELL_FREE, 0);
    add_row(mk(OP_WINDOW, 0, 0, 0, 63, -1), 1, CELL_FREE, 0);
    add_row(mk(OP_READ, 0, 0, 0, 0, 0), 1, CELL_SCANNED, 63998);
    add_row(mk(OP_READ, 1, 1, 0, 0, 0), 1, CELL_OBSTACLE, 64000);
    add_row(mk(OP_WRITE, 255, 0, CELL_OBSTACLE, 0, 0), 0, CELL_FREE, 0);
    add_row(mk(OP_WRITE, 2, 2, CELL_FREE, 0, 0), 0, CELL_FREE, 0);
    add_row(mk(OP_READ, 5, 5, 0, 0, 0), 1, CELL_FREE, 64000);
    idle_on = 1'b1;
    foreach (stim_q[i]) begin
      int g;
      g = draw_gap();
      if (g > 0) begin
        in_valid <= 1'b0;
        repeat (g) @(posedge clk);
      end
      send(stim_q[i].it, stim_q[i].known, stim_q[i].want);
    end

    run_phase(64, 64, 4, 70, 3, 1'b1);
    run_phase(4, 4, 2, 50, 63, 1'b0);
    run_phase(1, 64, 3, 35, 2, 1'b0);
    run_phase(0, 100, 0, 30, 3, 1'b0);
    run_phase(64, 1, 7, 30, 3, 1'b0);
    run_phase(2, 3, 1, 30, 63, 1'b0);

    // Drive one accumulator into its upper saturation limit and back down.
    run_phase(1, 1, 1, 0, 0, 1'b0);
    idle_on = 1'b0;
    send_pred(mk(OP_WRITE, 0, 0, CELL_SCANNED, 0, 0));
    repeat (260) send_pred(mk(OP_WINDOW, 0, 0, 0, 0, 32767));
    send_pred(mk(OP_READ, 0, 0, 0, 0, 0));
    repeat (3) send_pred(mk(OP_WINDOW, 0, 0, 0, 0, -32768));
    send_pred(mk(OP_READ, 0, 0, 0, 0, 0));

    drain();
    if (errs == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
